// File: rtl/bbf_pkg.sv
`default_nettype none

package bbf_pkg;

	localparam int COEF_W     = 24;
	localparam int ORDER_W    = 2;
	localparam int CFG_IDX_W  = 3;

	// order code that drops the second-back taps, every other code runs second order
	localparam logic [ORDER_W-1:0] ORDER_FIRST  = 2'd1;
	localparam logic [ORDER_W-1:0] ORDER_SECOND = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_X0      = 3'd0,
		REG_GAIN_X1      = 3'd1,
		REG_GAIN_X2      = 3'd2,
		REG_GAIN_Y1      = 3'd3,
		REG_GAIN_Y2      = 3'd4,
		REG_ORDER_SEL    = 3'd5
	} bbf_reg_e;

	typedef struct packed {
		logic signed [COEF_W-1:0]  gain_x0;
		logic signed [COEF_W-1:0]  gain_x1;
		logic signed [COEF_W-1:0]  gain_x2;
		logic signed [COEF_W-1:0]  gain_y1;
		logic signed [COEF_W-1:0]  gain_y2;
		logic        [ORDER_W-1:0] order_sel;
	} bbf_coef_t;

endpackage

`default_nettype wire

// File: rtl/bbf_cfg_regs.sv
`default_nettype none

module bbf_cfg_regs #(
	parameter int COEF_FRAC_BITS = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bbf_pkg::COEF_W-1:0]     cfg_data,
	output bbf_pkg::bbf_coef_t                  coef
);

	// 1.0 in the coefficient format
	localparam logic [bbf_pkg::COEF_W-1:0] UNITY_GAIN =
		bbf_pkg::COEF_W'(64'd1 << COEF_FRAC_BITS);

	bbf_pkg::bbf_coef_t coef_q;

	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.gain_x0      <= UNITY_GAIN;
			coef_q.gain_x1      <= '0;
			coef_q.gain_x2      <= '0;
			coef_q.gain_y1      <= '0;
			coef_q.gain_y2      <= '0;
			coef_q.order_sel    <= bbf_pkg::ORDER_SECOND;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bbf_pkg::bbf_reg_e'(cfg_index))
				bbf_pkg::REG_GAIN_X0:      coef_q.gain_x0 <= cfg_data;
				bbf_pkg::REG_GAIN_X1:      coef_q.gain_x1 <= cfg_data;
				bbf_pkg::REG_GAIN_X2:      coef_q.gain_x2 <= cfg_data;
				bbf_pkg::REG_GAIN_Y1:      coef_q.gain_y1 <= cfg_data;
				bbf_pkg::REG_GAIN_Y2:      coef_q.gain_y2 <= cfg_data;
				bbf_pkg::REG_ORDER_SEL:    coef_q.order_sel <= cfg_data[bbf_pkg::ORDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/bbf_core.sv
`default_nettype none

module bbf_core #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bbf_pkg::bbf_coef_t             coef,
	input  wire logic                           advance,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                           restart,
	output logic signed [SAMPLE_WIDTH-1:0]      filtered,
	output logic                                saturated
);

	localparam int PROD_W = bbf_pkg::COEF_W + SAMPLE_WIDTH;
	localparam int ACC_W  = PROD_W + 3;

	localparam logic signed [ACC_W-1:0] ROUND_C =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] x_prev1_q, x_prev2_q, y_prev1_q, y_prev2_q;
	logic                           primed_q;

	logic signed [PROD_W-1:0] p_x0, p_x1, p_x2, p_y1, p_y2;
	logic signed [PROD_W-1:0] p_x2_m, p_y2_m;
	logic                     tap2_en;
	logic signed [ACC_W-1:0]  acc, rounded, shifted;
	logic                     clip_hi, clip_lo, prime;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	assign p_x0 = coef.gain_x0 * sample;
	assign p_x1 = coef.gain_x1 * x_prev1_q;
	assign p_x2 = coef.gain_x2 * x_prev2_q;
	assign p_y1 = coef.gain_y1 * y_prev1_q;
	assign p_y2 = coef.gain_y2 * y_prev2_q;

	assign tap2_en = (coef.order_sel != bbf_pkg::ORDER_FIRST);
	assign p_x2_m  = tap2_en ? p_x2 : '0;
	assign p_y2_m  = tap2_en ? p_y2 : '0;

	assign acc = ACC_W'(p_x0) + ACC_W'(p_x1) + ACC_W'(p_x2_m)
		- ACC_W'(p_y1) - ACC_W'(p_y2_m);

	// round half up, arithmetic shift floors
	assign rounded = acc + ROUND_C;
	assign shifted = rounded >>> COEF_FRAC_BITS;

	assign clip_hi = (shifted > SAT_HI);
	assign clip_lo = (shifted < SAT_LO);

	always_comb begin
		if (clip_hi) begin
			y_sat = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (clip_lo) begin
			y_sat = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			y_sat = shifted[SAMPLE_WIDTH-1:0];
		end
	end

	// priming item passes through and loads the whole history
	assign prime     = restart || !primed_q;
	assign filtered  = prime ? sample : y_sat;
	assign saturated = !prime && (clip_hi || clip_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_prev1_q <= '0;
			x_prev2_q <= '0;
			y_prev1_q <= '0;
			y_prev2_q <= '0;
			primed_q  <= 1'b0;
		end else if (advance) begin
			primed_q <= 1'b1;
			if (prime) begin
				x_prev1_q <= sample;
				x_prev2_q <= sample;
				y_prev1_q <= sample;
				y_prev2_q <= sample;
			end else begin
				x_prev1_q <= sample;
				x_prev2_q <= x_prev1_q;
				y_prev1_q <= y_sat;
				y_prev2_q <= y_prev1_q;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/butterworth_biquad_filter_top.sv
// an accepted input item is registered in the input stage, then in the result register on the master side
// throughput: one item per cycle while the master side does not stall; the five-product sum and the output
// feedback close combinationally between the input stage and the result register
// reset (arst_n low, asynchronous): stages emptied, history cleared and unprimed,
// coefficients back to unity gain, second order
`default_nettype none

module butterworth_biquad_filter_top #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// [SAMPLE_WIDTH-1:0] sample, rest zero
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// [0] restart
	input  wire logic [0:0]                     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [SAMPLE_WIDTH-1:0] filtered, rest zero
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
	// [0] saturated
	output logic [0:0]                          m_axis_tuser,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bbf_pkg::COEF_W-1:0]     cfg_data
);

	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	bbf_pkg::bbf_coef_t coef;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           restart_s1;
	logic                           advance;

	logic signed [SAMPLE_WIDTH-1:0] filtered;
	logic                           saturated;
	logic                           m_valid_q;
	logic [SAMPLE_WIDTH-1:0]        filtered_q;
	logic                           saturated_q;

	bbf_cfg_regs #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// input stage moves on whenever the result register is free or drains
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1  <= s_axis_tdata[SAMPLE_WIDTH-1:0];
			restart_s1 <= s_axis_tuser[0];
		end
	end

	bbf_core #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.advance   (advance),
		.sample    (sample_s1),
		.restart   (restart_s1),
		.filtered  (filtered),
		.saturated (saturated)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filtered_q  <= filtered;
			saturated_q <= saturated;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = DATA_W'(filtered_q);
	assign m_axis_tuser  = saturated_q;

endmodule

`default_nettype wire

// File: rtl/bbf_checker.sv
`default_nettype none

module bbf_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_axis_tvalid,
	input wire logic                               s_axis_tready,
	input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
	input wire logic [0:0]                         s_axis_tuser,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
	input wire logic [0:0]                         m_axis_tuser
);

	localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// input side only backs up when the result side is full and stalled
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while result side free");

	// a restart item into an empty result stage comes out unchanged
	a_prime_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) ##1 !m_axis_tvalid |=>
			m_axis_tvalid
			&& (m_axis_tdata[SAMPLE_WIDTH-1:0] == $past(s_axis_tdata[SAMPLE_WIDTH-1:0], 2))
			&& !m_axis_tuser[0])
		else $error("priming item did not pass through");

	// clipped result sits on a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata[SAMPLE_WIDTH-1:0] == OUT_MAX)
			|| (m_axis_tdata[SAMPLE_WIDTH-1:0] == OUT_MIN))
		else $error("saturated flag without limit value");

endmodule

bind butterworth_biquad_filter_top bbf_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bbf_checker (.*);

`default_nettype wire
